>>> rtl/key_scanner_debounce_note_map_top_defines.svh
// Assertion macros shared by the key scanner RTL.
`ifndef KEY_SCANNER_DEBOUNCE_NOTE_MAP_TOP_DEFINES_SVH
`define KEY_SCANNER_DEBOUNCE_NOTE_MAP_TOP_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define KSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ksd_pkg.sv
// Types, constants and note tables for the key scanner.
`default_nettype none
package ksd_pkg;

    // Field widths.
    localparam int unsigned KEY_W    = 6;
    localparam int unsigned NOTE_W   = 7;
    localparam int unsigned LNOTE_W  = 6;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned LAYOUT_W = 2;
    localparam int unsigned TRANS_W  = 4;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SLOT_W   = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    // Default sizes.
    localparam int unsigned DEF_NUM_SWITCHES = 40;
    localparam int unsigned DEF_NUM_KEYS     = 37;

    // Table shapes and scan sequencer timing.
    localparam int unsigned NUM_LAYOUTS   = 3;
    localparam int unsigned NUM_SEMITONES = 12;
    localparam int unsigned LAYOUT_COLS   = 37;
    localparam int unsigned ORDER_LEN     = 40;
    localparam int unsigned FIRST_READ    = 3;
    localparam logic [SLOT_W-1:0] SLOT_NONE = 7'd127;

    // Register reset values.
    localparam logic [CNT_W-1:0] RST_DEBOUNCE      = 4'd2;
    localparam logic [KEY_W-1:0] RST_LAYOUT_KEY    = 6'd33;
    localparam logic [KEY_W-1:0] RST_TRANSPOSE_KEY = 6'd34;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_LAYOUT_KEY    = 2'd1,
        CFG_TRANSPOSE_KEY = 2'd2
    } cfg_index_t;

    // Event codes.
    typedef enum logic [KIND_W-1:0] {
        EV_NONE      = 3'd0,
        EV_NOTE_ON   = 3'd1,
        EV_NOTE_OFF  = 3'd2,
        EV_LAYOUT    = 3'd3,
        EV_TRANSPOSE = 3'd4
    } event_kind_t;

    // Debounce state of one key, held by one cell of the ring.
    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  count;
        logic [NOTE_W-1:0] held;
    } key_state_t;

    // Event produced by one scan tick.
    typedef struct packed {
        event_kind_t       kind;
        logic [KEY_W-1:0]  key;
        logic [NOTE_W-1:0] note;
    } event_t;

    // Order in which the switches are wired to the note slots.
    localparam logic [KEY_W-1:0] SWITCH_ORDER [ORDER_LEN] = '{
        6'd3,  6'd2,  6'd1,  6'd0,  6'd5,  6'd6,  6'd7,  6'd8,  6'd4,  6'd12,
        6'd13, 6'd14, 6'd15, 6'd9,  6'd10, 6'd11, 6'd16, 6'd20, 6'd21, 6'd22,
        6'd23, 6'd17, 6'd30, 6'd29, 6'd28, 6'd24, 6'd19, 6'd18, 6'd25, 6'd26,
        6'd27, 6'd32, 6'd31, 6'd39, 6'd38, 6'd37, 6'd36, 6'd33, 6'd34, 6'd35
    };

    // Three note layouts over the slots.
    localparam logic [LNOTE_W-1:0] LAYOUT_NOTES [NUM_LAYOUTS][LAYOUT_COLS] = '{
        '{6'd30, 6'd35, 6'd40, 6'd45, 6'd27, 6'd32, 6'd37, 6'd42, 6'd47, 6'd24,
          6'd29, 6'd34, 6'd39, 6'd44, 6'd49, 6'd21, 6'd26, 6'd31, 6'd36, 6'd41,
          6'd46, 6'd51, 6'd23, 6'd28, 6'd33, 6'd38, 6'd43, 6'd48, 6'd25, 6'd30,
          6'd35, 6'd40, 6'd45, 6'd27, 6'd32, 6'd37, 6'd42},
        '{6'd45, 6'd49, 6'd53, 6'd57, 6'd48, 6'd42, 6'd46, 6'd50, 6'd54, 6'd31,
          6'd35, 6'd39, 6'd43, 6'd47, 6'd51, 6'd24, 6'd28, 6'd32, 6'd36, 6'd40,
          6'd44, 6'd48, 6'd21, 6'd25, 6'd29, 6'd33, 6'd37, 6'd41, 6'd18, 6'd22,
          6'd26, 6'd30, 6'd34, 6'd15, 6'd19, 6'd23, 6'd27},
        '{6'd27, 6'd31, 6'd35, 6'd39, 6'd26, 6'd30, 6'd34, 6'd38, 6'd42, 6'd25,
          6'd29, 6'd33, 6'd37, 6'd41, 6'd45, 6'd24, 6'd28, 6'd32, 6'd36, 6'd40,
          6'd44, 6'd48, 6'd27, 6'd31, 6'd35, 6'd39, 6'd43, 6'd47, 6'd30, 6'd34,
          6'd38, 6'd42, 6'd46, 6'd33, 6'd37, 6'd41, 6'd45}
    };

    // Slot of a switch, or SLOT_NONE when no slot maps to it.
    function automatic logic [SLOT_W-1:0] key_slot(input logic [KEY_W-1:0] sw,
                                                   input int unsigned num_keys);
        logic [SLOT_W-1:0] slot;
        slot = SLOT_NONE;
        for (int j = 0; j < ORDER_LEN; j++) begin
            if (j < num_keys && j < LAYOUT_COLS && SWITCH_ORDER[j] == sw) begin
                slot = SLOT_W'(j);
            end
        end
        return slot;
    endfunction

    // Layout note of a slot; zero outside the table.
    function automatic logic [LNOTE_W-1:0] layout_note(input logic [LAYOUT_W-1:0] layout,
                                                       input logic [KEY_W-1:0] slot);
        logic [LNOTE_W-1:0] n;
        n = '0;
        if (slot < KEY_W'(LAYOUT_COLS) && layout < LAYOUT_W'(NUM_LAYOUTS)) begin
            n = LAYOUT_NOTES[layout][slot];
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ksd_cell.sv
// One cell of the key state ring: holds the debounce state of one key.
`default_nettype none
module ksd_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               shift_en,
    input  wire ksd_pkg::key_state_t d,
    output ksd_pkg::key_state_t     q
);

    ksd_pkg::key_state_t state_reg;
    ksd_pkg::key_state_t state_next;

    // Take the neighbour's state when the ring advances.
    always_comb begin
        state_next = shift_en ? d : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule
`default_nettype wire

>>> rtl/ksd_update.sv
// Debounce and event logic for the key at the head of the ring.
`default_nettype none
module ksd_update #(
    parameter int unsigned NUM_KEYS = ksd_pkg::DEF_NUM_KEYS
) (
    input  wire logic                          read_en,
    input  wire logic                          data_bit,
    input  wire logic [ksd_pkg::KEY_W-1:0]     key_idx,
    input  wire ksd_pkg::key_state_t           head,
    input  wire logic [ksd_pkg::CNT_W-1:0]     debounce_reads,
    input  wire logic [ksd_pkg::KEY_W-1:0]     layout_key,
    input  wire logic [ksd_pkg::KEY_W-1:0]     transpose_key,
    input  wire logic [ksd_pkg::LAYOUT_W-1:0]  layout,
    input  wire logic [ksd_pkg::TRANS_W-1:0]   transpose,
    output ksd_pkg::key_state_t                head_next,
    output ksd_pkg::event_t                    evt,
    output logic [ksd_pkg::LAYOUT_W-1:0]       layout_next,
    output logic [ksd_pkg::TRANS_W-1:0]        transpose_next
);

    logic [ksd_pkg::SLOT_W-1:0]  slot;
    logic [ksd_pkg::CNT_W:0]     count_inc;
    logic                        reached;
    logic [ksd_pkg::NOTE_W-1:0]  on_note;

    // Slot lookup and the note it plays in the current layout.
    assign slot      = ksd_pkg::key_slot(key_idx, NUM_KEYS);
    assign on_note   = ksd_pkg::NOTE_W'(ksd_pkg::layout_note(layout,
                                                             slot[ksd_pkg::KEY_W-1:0]))
                     + ksd_pkg::NOTE_W'(transpose);
    assign count_inc = {1'b0, head.count} + 1'b1;
    assign reached   = count_inc >= {1'b0, debounce_reads};

    // Debounce one read and turn an accepted change into an event.
    always_comb begin
        head_next      = head;
        evt.kind       = ksd_pkg::EV_NONE;
        evt.key        = '0;
        evt.note       = '0;
        layout_next    = layout;
        transpose_next = transpose;
        if (read_en) begin
            if (head.accepted != data_bit) begin
                if (reached) begin
                    head_next.count    = '0;
                    head_next.accepted = data_bit;
                    if (data_bit) begin
                        if (key_idx == layout_key) begin
                            layout_next = (layout == ksd_pkg::LAYOUT_W'(ksd_pkg::NUM_LAYOUTS - 1))
                                        ? '0 : layout + 1'b1;
                            evt.kind    = ksd_pkg::EV_LAYOUT;
                            evt.key     = key_idx;
                        end else if (key_idx == transpose_key) begin
                            transpose_next =
                                (transpose == ksd_pkg::TRANS_W'(ksd_pkg::NUM_SEMITONES - 1))
                                ? '0 : transpose + 1'b1;
                            evt.kind = ksd_pkg::EV_TRANSPOSE;
                            evt.key  = key_idx;
                        end else if (slot < ksd_pkg::SLOT_W'(ksd_pkg::LAYOUT_COLS)) begin
                            head_next.held = on_note;
                            evt.kind       = ksd_pkg::EV_NOTE_ON;
                            evt.key        = key_idx;
                            evt.note       = on_note;
                        end
                    end else if (key_idx != layout_key && key_idx != transpose_key) begin
                        head_next.held = '0;
                        evt.kind       = ksd_pkg::EV_NOTE_OFF;
                        evt.key        = key_idx;
                        evt.note       = head.held;
                    end
                end else begin
                    head_next.count = count_inc[ksd_pkg::CNT_W-1:0];
                end
            end else begin
                head_next.count = '0;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/ksd_out_buf.sv
// Two-entry output buffer with a skid stage between the scan logic and the result channel.
`default_nettype none
module ksd_out_buf #(
    parameter int unsigned DATA_W = 27
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [DATA_W-1:0] s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_data
);

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0] skid_data_reg, skid_data_next;
    logic              push;
    logic              pop;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    // Fill the output register first, the skid register when it is stalled.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = s_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = s_data;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

>>> rtl/key_scanner_debounce_note_map_top.sv
// Top level of the key scanner: drives the shift register, debounces keys, maps them to notes.
//
// Each input transaction on s_ is one scan tick; s_tdata[0] is the serial
// data bit sampled from the key shift register. Every tick yields exactly
// one result transaction on m_: the latch and clock strobes for the shift
// register, an event (m_tuser) and the current layout and transpose.
// The sequencer runs NUM_SWITCHES+4 ticks per frame: latch at tick 0,
// clock at ticks 1 to NUM_SWITCHES, key (tick-3) read at ticks 3 to
// NUM_SWITCHES+2. Key states sit in a ring of cells that advances one
// place per read, so the key being read is always at the head cell.
// The result is registered in the output buffer; one tick is taken every
// cycle while s_tready is high, limited by the single head-cell update loop.
// A two-entry output buffer lets one more tick in while a result waits;
// with both entries full s_tready drops until the receiver takes one.
// Configuration writes on cfg_ are taken in any cycle (cfg_ready is high).
// Reset (aresetn low, synchronous) releases all keys, clears counters,
// held notes, layout, transpose and phase, and restores register defaults.
`default_nettype none
module key_scanner_debounce_note_map_top #(
    parameter int unsigned NUM_SWITCHES = ksd_pkg::DEF_NUM_SWITCHES,
    parameter int unsigned NUM_KEYS     = ksd_pkg::DEF_NUM_KEYS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Scan tick input.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [0] data_bit
    // Result output.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] latch_out, [1] clock_out, [7:2] key_index, [14:8] note,
    // [16:15] layout_now, [20:17] transpose_now
    output logic [23:0]                         m_tdata,
    output logic [ksd_pkg::KIND_W-1:0]          m_tuser,   // [2:0] event_kind
    // Configuration writes.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ksd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ksd_pkg::CFG_DATA_W-1:0] cfg_data
);

    `include "key_scanner_debounce_note_map_top_defines.svh"

    localparam int unsigned NUM_PHASES = NUM_SWITCHES + 4;
    localparam int unsigned PHASE_W    = $clog2(NUM_PHASES);
    localparam int unsigned LAST_PHASE = NUM_PHASES - 1;
    localparam int unsigned OUT_W      = 24 + ksd_pkg::KIND_W;

    logic [PHASE_W-1:0]             phase_reg, phase_next;
    logic [ksd_pkg::CNT_W-1:0]      debounce_reg;
    logic [ksd_pkg::KEY_W-1:0]      layout_key_reg;
    logic [ksd_pkg::KEY_W-1:0]      transpose_key_reg;
    logic [ksd_pkg::LAYOUT_W-1:0]   layout_reg, layout_next;
    logic [ksd_pkg::TRANS_W-1:0]    transpose_reg, transpose_next;
    logic                           s_fire;
    logic                           read_en;
    logic                           latch_out;
    logic                           clock_out;
    logic [ksd_pkg::KEY_W-1:0]      key_idx;
    ksd_pkg::key_state_t            cell_q [NUM_SWITCHES];
    ksd_pkg::key_state_t            head_next;
    ksd_pkg::event_t                evt;
    logic [OUT_W-1:0]               out_item;
    logic [OUT_W-1:0]               m_item;
    logic                           shift_en;

    // Scan sequencer decode.
    assign s_fire    = s_tvalid && s_tready;
    assign read_en   = phase_reg >= PHASE_W'(ksd_pkg::FIRST_READ)
                    && phase_reg < PHASE_W'(NUM_SWITCHES + ksd_pkg::FIRST_READ);
    assign latch_out = phase_reg == '0;
    assign clock_out = phase_reg >= PHASE_W'(1) && phase_reg <= PHASE_W'(NUM_SWITCHES);
    assign key_idx   = ksd_pkg::KEY_W'(phase_reg - PHASE_W'(ksd_pkg::FIRST_READ));
    assign shift_en  = s_fire && read_en;
    assign phase_next = (phase_reg == PHASE_W'(LAST_PHASE)) ? '0 : phase_reg + 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= ksd_pkg::RST_DEBOUNCE;
            layout_key_reg    <= ksd_pkg::RST_LAYOUT_KEY;
            transpose_key_reg <= ksd_pkg::RST_TRANSPOSE_KEY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ksd_pkg::CFG_DEBOUNCE:
                    debounce_reg <= cfg_data[ksd_pkg::CNT_W-1:0];
                ksd_pkg::CFG_LAYOUT_KEY:
                    layout_key_reg <= cfg_data[ksd_pkg::KEY_W-1:0];
                ksd_pkg::CFG_TRANSPOSE_KEY:
                    transpose_key_reg <= cfg_data[ksd_pkg::KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Phase, layout and transpose advance with each accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            layout_reg    <= '0;
            transpose_reg <= '0;
        end else if (s_fire) begin
            phase_reg     <= phase_next;
            layout_reg    <= layout_next;
            transpose_reg <= transpose_next;
        end
    end

    // Ring of key cells; the head cell is the key read this tick.
    for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_cell
        if (i == NUM_SWITCHES - 1) begin : g_tail
            ksd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d        (head_next),
                .q        (cell_q[i])
            );
        end else begin : g_body
            ksd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d        (cell_q[i+1]),
                .q        (cell_q[i])
            );
        end
    end

    ksd_update #(
        .NUM_KEYS (NUM_KEYS)
    ) u_update (
        .read_en        (read_en),
        .data_bit       (s_tdata[0]),
        .key_idx        (key_idx),
        .head           (cell_q[0]),
        .debounce_reads (debounce_reg),
        .layout_key     (layout_key_reg),
        .transpose_key  (transpose_key_reg),
        .layout         (layout_reg),
        .transpose      (transpose_reg),
        .head_next      (head_next),
        .evt            (evt),
        .layout_next    (layout_next),
        .transpose_next (transpose_next)
    );

    // Pack the result: event kind on top, then the stream data word.
    assign out_item = {evt.kind, 3'b000, transpose_next, layout_next, evt.note, evt.key,
                       clock_out, latch_out};

    ksd_out_buf #(
        .DATA_W (OUT_W)
    ) u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (out_item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_item)
    );

    assign m_tdata = m_item[23:0];
    assign m_tuser = m_item[OUT_W-1:24];

    // Checks on the sequencer, the global note state and the ring.
    `KSD_ASSERT_SAME(a_phase_range, 1'b1,
                     phase_reg <= PHASE_W'(LAST_PHASE),
                     "phase out of range")
    `KSD_ASSERT_NEXT(a_phase_wrap,
                     s_fire && phase_reg == PHASE_W'(LAST_PHASE),
                     phase_reg == '0,
                     "phase did not wrap")
    `KSD_ASSERT_SAME(a_note_state, 1'b1,
                     layout_reg < ksd_pkg::LAYOUT_W'(ksd_pkg::NUM_LAYOUTS)
                     && transpose_reg < ksd_pkg::TRANS_W'(ksd_pkg::NUM_SEMITONES),
                     "layout or transpose out of range")
    `KSD_ASSERT_NEXT(a_note_held,
                     s_fire && evt.kind == ksd_pkg::EV_NOTE_ON,
                     cell_q[NUM_SWITCHES-1].held == $past(evt.note),
                     "note-on not held in ring")

endmodule
`default_nettype wire
